// ===== rtl/hashed_id_name_table_top_macros.svh =====
// assertion macros for the hashed id name table
`ifndef HASHED_ID_NAME_TABLE_TOP_MACROS_SVH
`define HASHED_ID_NAME_TABLE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define HIDNT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HIDNT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define HIDNT_ASSERT(lbl, clk, rst_n, prop, msg)
`define HIDNT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/hidnt_pkg.sv =====
package hidnt_pkg;

	localparam int TABLE_SIZE_DEF = 1024;
	localparam int NAME_BYTES_DEF = 8;
	localparam int HASH_GAP       = 20;
	localparam int PROBE_STEP     = 5;

	localparam int KEY_W    = 16;
	localparam int NAME_W   = 64;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] RES_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] RES_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] RES_FULL = 2'd2;

	typedef struct packed {
		logic clr_step;
		logic load_item;
		logic fast_chk;
		logic load_idx;
		logic rd_en;
		logic chk;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic fast_hit;
		logic stop;
		logic wrap_full;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== rtl/hidnt_ctrl.sv =====
`include "hashed_id_name_table_top_macros.svh"

module hidnt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output hidnt_pkg::dp_cmd_t  cmd,
	input  hidnt_pkg::dp_stat_t st
);
	import hidnt_pkg::*;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_HASH_A = 3'd2;
	localparam logic [2:0] S_HASH_B = 3'd3;
	localparam logic [2:0] S_HASH_C = 3'd4;
	localparam logic [2:0] S_READ   = 3'd5;
	localparam logic [2:0] S_CHECK  = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_HASH_A;
				end
			end
			S_HASH_A: begin
				cmd.fast_chk = 1'b1;
				state_d      = st.fast_hit ? S_DONE : S_HASH_B;
			end
			S_HASH_B: begin
				state_d = S_HASH_C;
			end
			S_HASH_C: begin
				cmd.load_idx = 1'b1;
				state_d      = S_READ;
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = S_CHECK;
			end
			S_CHECK: begin
				cmd.chk = 1'b1;
				state_d = (st.stop || st.wrap_full) ? S_DONE : S_READ;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	`HIDNT_ASSERT(a_mem_cmd_excl, clk, arst_n, $onehot0({cmd.clr_step, cmd.rd_en, cmd.chk}), "memory commands overlap")
	`HIDNT_ASSERT(a_clear_no_take, clk, arst_n, (state_q == S_CLEAR) |-> !in_ready, "transaction taken during clear")

endmodule

// ===== rtl/hidnt_dp.sv =====
`include "hashed_id_name_table_top_macros.svh"

module hidnt_dp #(
	parameter int TABLE_SIZE = hidnt_pkg::TABLE_SIZE_DEF,
	parameter int NAME_BYTES = hidnt_pkg::NAME_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hidnt_pkg::dp_cmd_t              cmd,
	output hidnt_pkg::dp_stat_t             st,
	input  logic                            op,
	input  logic [hidnt_pkg::KEY_W-1:0]     key,
	input  logic [hidnt_pkg::NAME_W-1:0]    entry_name,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [hidnt_pkg::STATUS_W-1:0]  status,
	output logic [hidnt_pkg::NAME_W-1:0]    found_name
);
	import hidnt_pkg::*;

	localparam int IDX_W     = $clog2(TABLE_SIZE);
	localparam int MNAME_W   = 8 * NAME_BYTES;
	localparam int HASH_SPAN = TABLE_SIZE - HASH_GAP;
	localparam logic [32:0] HASH_RECIP = 33'((64'd1 << 32) / HASH_SPAN);
	localparam int PROD_W    = KEY_W + 33;

	function automatic logic [MNAME_W-1:0] norm_name(input logic [NAME_W-1:0] raw);
		logic                keep;
		logic [MNAME_W-1:0]  res;
		keep = 1'b1;
		res  = '0;
		for (int i = 0; i < NAME_BYTES; i++) begin
			if (raw[8*i +: 8] == 8'd0) begin
				keep = 1'b0;
			end
			if (keep) begin
				res[8*i +: 8] = raw[8*i +: 8];
			end
		end
		return res;
	endfunction

	logic [MNAME_W-1:0] names_mem [TABLE_SIZE];
	logic [KEY_W-1:0]   keys_mem  [TABLE_SIZE];

	logic               op_q;
	logic [KEY_W-1:0]   key_q;
	logic [MNAME_W-1:0] name_q;

	logic [PROD_W-1:0]  prod_s1;
	logic [KEY_W-1:0]   quo;
	logic [31:0]        qm_s2;
	logic [KEY_W-1:0]   key_s2;
	logic [KEY_W-1:0]   rem;
	logic [KEY_W-1:0]   rem_fix;

	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   start_q;
	logic [IDX_W:0]     step_sum;
	logic [IDX_W:0]     step_wrap;
	logic [IDX_W-1:0]   idx_next;

	logic [MNAME_W-1:0] rd_name_q;
	logic [KEY_W-1:0]   rd_key_q;
	logic               occ;
	logic               stop;
	logic               wr_ins;
	logic               lh_upd;
	logic               fast_hit;

	logic               lh_valid_q;
	logic [KEY_W-1:0]   lh_key_q;
	logic [MNAME_W-1:0] lh_name_q;

	logic [STATUS_W-1:0] res_status_q;
	logic [NAME_W-1:0]   res_name_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [NAME_W-1:0]   out_name_q;

	// key mod span by reciprocal multiply and one correction
	assign quo     = prod_s1[32 +: KEY_W];
	assign rem     = key_s2 - qm_s2[KEY_W-1:0];
	assign rem_fix = (rem >= KEY_W'(HASH_SPAN)) ? rem - KEY_W'(HASH_SPAN) : rem;

	assign step_sum  = {1'b0, idx_q} + (IDX_W+1)'(PROBE_STEP);
	assign step_wrap = (step_sum >= (IDX_W+1)'(TABLE_SIZE)) ?
	                   step_sum - (IDX_W+1)'(TABLE_SIZE) : step_sum;
	assign idx_next  = step_wrap[IDX_W-1:0];

	assign occ      = (rd_name_q[7:0] != 8'd0);
	assign stop     = !occ || (rd_key_q == key_q);
	assign wr_ins   = cmd.chk && stop && op_q && !occ;
	assign lh_upd   = cmd.chk && stop && !op_q && occ;
	assign fast_hit = !op_q && lh_valid_q && (key_q == lh_key_q);

	assign st.clr_last  = (idx_q == IDX_W'(TABLE_SIZE - 1));
	assign st.fast_hit  = fast_hit;
	assign st.stop      = stop;
	assign st.wrap_full = (idx_next == start_q);
	assign st.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q   <= op;
			key_q  <= key;
			name_q <= norm_name(entry_name);
		end
		prod_s1 <= PROD_W'(key_q) * PROD_W'(HASH_RECIP);
		qm_s2   <= 32'(quo) * 32'(HASH_SPAN);
		key_s2  <= key_q;
		if (cmd.load_idx) begin
			start_q <= rem_fix[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			names_mem[idx_q] <= '0;
		end else if (wr_ins) begin
			names_mem[idx_q] <= name_q;
			keys_mem[idx_q]  <= key_q;
		end
		if (cmd.rd_en) begin
			rd_name_q <= names_mem[idx_q];
			rd_key_q  <= keys_mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.clr_step) begin
			idx_q <= st.clr_last ? '0 : idx_q + IDX_W'(1);
		end else if (cmd.load_idx) begin
			idx_q <= rem_fix[IDX_W-1:0];
		end else if (cmd.chk && !stop) begin
			idx_q <= idx_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lh_valid_q <= 1'b0;
			lh_key_q   <= '0;
			lh_name_q  <= '0;
		end else if (lh_upd) begin
			lh_valid_q <= 1'b1;
			lh_key_q   <= key_q;
			lh_name_q  <= rd_name_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fast_chk && fast_hit) begin
			res_status_q <= RES_OK;
			res_name_q   <= NAME_W'(lh_name_q);
		end else if (cmd.chk) begin
			if (stop) begin
				if (op_q) begin
					res_status_q <= occ ? RES_MISS : RES_OK;
					res_name_q   <= '0;
				end else begin
					res_status_q <= occ ? RES_OK : RES_MISS;
					res_name_q   <= occ ? NAME_W'(rd_name_q) : '0;
				end
			end else begin
				res_status_q <= RES_FULL;
				res_name_q   <= '0;
			end
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_name_q   <= res_name_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign found_name = out_name_q;

	`HIDNT_ASSERT(a_idx_range, clk, arst_n, ({1'b0, idx_q} < (IDX_W+1)'(TABLE_SIZE)), "probe index out of table")
	`HIDNT_ASSERT(a_out_free, clk, arst_n, cmd.out_load |-> (!out_valid_q || out_ready), "pending result overwritten")
	`HIDNT_NEVER(a_lh_nonempty, clk, arst_n, lh_valid_q && (lh_name_q[7:0] == 8'd0), "empty name cached as hit")
	`HIDNT_ASSERT(a_start_home, clk, arst_n, cmd.load_idx |=> (idx_q == start_q), "probe not started at home slot")

endmodule

// ===== rtl/hashed_id_name_table_top.sv =====
// Open-addressed id to name table. Each transaction is a lookup (op 0) or an insert (op 1)
// and gives one result. After reset the name store is swept clear, one slot a cycle,
// before the first transaction is taken. A lookup that repeats the last probed hit is
// answered from a cached copy without a table read; otherwise each probe is one registered
// read of the single-port slot memory followed by a compare state. Up to TABLE_SIZE slots
// are probed in a full table, or TABLE_SIZE/5 when TABLE_SIZE is a multiple of 5. The next
// transaction is taken while a result still waits at the output.
module hashed_id_name_table_top #(
	parameter int TABLE_SIZE = hidnt_pkg::TABLE_SIZE_DEF,
	parameter int NAME_BYTES = hidnt_pkg::NAME_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            op,
	input  logic [hidnt_pkg::KEY_W-1:0]     key,
	input  logic [hidnt_pkg::NAME_W-1:0]    entry_name,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [hidnt_pkg::STATUS_W-1:0]  status,
	output logic [hidnt_pkg::NAME_W-1:0]    found_name
);
	import hidnt_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t st;

	hidnt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.st       (st)
	);

	hidnt_dp #(
		.TABLE_SIZE (TABLE_SIZE),
		.NAME_BYTES (NAME_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.op         (op),
		.key        (key),
		.entry_name (entry_name),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.found_name (found_name)
	);

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import hidnt_pkg::*;

	localparam int TABLE_SIZE = TABLE_SIZE_DEF;
	localparam int NAME_BYTES = NAME_BYTES_DEF;
	localparam int HASH_SPAN  = TABLE_SIZE - HASH_GAP;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	localparam int RX_FREE   = 0;
	localparam int RX_SPARSE = 1;
	localparam int RX_COIN   = 2;
	localparam int RX_BEAT   = 3;

	localparam int RAND_ITEMS = 200;
	localparam int HOLD_AT    = 60;
	localparam int HOLD_LEN   = 400;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic                op;
		logic [KEY_W-1:0]    key;
		logic [NAME_W-1:0]   name;
	} table_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [NAME_W-1:0]   name;
	} answer_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                op = 1'b0;
	logic [KEY_W-1:0]    key = '0;
	logic [NAME_W-1:0]   entry_name = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [NAME_W-1:0]   found_name;

	hashed_id_name_table_top #(
		.TABLE_SIZE(TABLE_SIZE),
		.NAME_BYTES(NAME_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.key(key),
		.entry_name(entry_name),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.found_name(found_name)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// shadow copy of the table
	bit [NAME_W-1:0] slot_name [TABLE_SIZE];
	bit [KEY_W-1:0]  slot_key [TABLE_SIZE];
	bit              hit_valid;
	bit [KEY_W-1:0]  hit_key;
	bit [NAME_W-1:0] hit_name;
	int              occupied;

	table_req_t send_q[$];
	answer_t    due_answers[$];
	table_req_t drv_req;
	answer_t    mon_exp;
	answer_t    mon_new;
	int         sent_total;
	int         in_count;
	int         fail_count;
	int         idle_cycles;
	int         burst_left;
	int         gap_left;
	int         rx_mode;
	int         rx_mode_left;
	int         rx_cycle;
	int         hold_left;
	bit         hold_done;

	function automatic bit [NAME_W-1:0] trim_name(bit [NAME_W-1:0] raw);
		bit [NAME_W-1:0] trimmed;
		bit [7:0]        b;
		trimmed = '0;
		for (int i = 0; i < NAME_BYTES && i < 8; i++) begin
			b = raw[8*i +: 8];
			if (b == 8'd0)
				break;
			trimmed[8*i +: 8] = b;
		end
		return trimmed;
	endfunction

	function automatic int probe_slot(bit [KEY_W-1:0] k);
		int start;
		int idx;
		start = int'(k) % HASH_SPAN;
		idx = start;
		do begin
			if (slot_name[idx][7:0] == 8'd0 || slot_key[idx] == k)
				return idx;
			idx += PROBE_STEP;
			if (idx >= TABLE_SIZE)
				idx -= TABLE_SIZE;
		end while (idx != start);
		return -1;
	endfunction

	function automatic answer_t table_step(logic is_op, bit [KEY_W-1:0] k,
			bit [NAME_W-1:0] raw);
		answer_t a;
		int      slot;
		a.status = RES_OK;
		a.name = '0;
		if (is_op == OP_LOOKUP && hit_valid && k == hit_key) begin
			a.name = hit_name;
			return a;
		end
		slot = probe_slot(k);
		if (slot < 0) begin
			a.status = RES_FULL;
		end else if (is_op == OP_INSERT) begin
			if (slot_name[slot][7:0] != 8'd0) begin
				a.status = RES_MISS;
			end else begin
				slot_name[slot] = trim_name(raw);
				slot_key[slot] = k;
				if (slot_name[slot][7:0] != 8'd0)
					occupied++;
			end
		end else if (slot_name[slot][7:0] != 8'd0) begin
			a.name = slot_name[slot];
			hit_valid = 1'b1;
			hit_key = k;
			hit_name = a.name;
		end else begin
			a.status = RES_MISS;
		end
		return a;
	endfunction

	function automatic bit [NAME_W-1:0] make_name();
		bit [NAME_W-1:0] n;
		int              pick;
		int              pos;
		n = {$urandom, $urandom};
		pick = $urandom_range(0, 9);
		pos = $urandom_range(1, 7);
		case (pick) inside
			0: n[7:0] = 8'd0;
			1: n = '1;
			2, 3: n[8*pos +: 8] = 8'd0;
			default: ;
		endcase
		return n;
	endfunction

	task automatic push_req(logic o, bit [KEY_W-1:0] k, bit [NAME_W-1:0] n);
		table_req_t r;
		r.op = o;
		r.key = k;
		r.name = n;
		send_q.push_back(r);
		sent_total++;
	endtask

	task automatic wait_drained();
		while (!(send_q.size() == 0 && in_count == sent_total && due_answers.size() == 0))
			@(negedge clk);
	endtask

	// sender: bursts with gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= OP_LOOKUP;
			key <= '0;
			entry_name <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!in_valid || in_ready) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (send_q.size() > 0) begin
				drv_req = send_q.pop_front();
				in_valid <= 1'b1;
				op <= drv_req.op;
				key <= drv_req.key;
				entry_name <= drv_req.name;
				if (burst_left <= 1) begin
					burst_left <= ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 30);
					gap_left <= $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_mode <= RX_FREE;
			rx_mode_left <= 0;
			rx_cycle <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && in_count >= HOLD_AT) begin
			out_ready <= 1'b0;
			hold_done <= 1'b1;
			hold_left <= HOLD_LEN;
		end else begin
			rx_cycle <= rx_cycle + 1;
			if (rx_mode_left == 0) begin
				rx_mode <= $urandom_range(RX_FREE, RX_BEAT);
				rx_mode_left <= $urandom_range(20, 200);
			end else begin
				rx_mode_left <= rx_mode_left - 1;
			end
			case (rx_mode)
				RX_FREE:   out_ready <= 1'b1;
				RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
				RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
				default:   out_ready <= (rx_cycle % 8) < 3;
			endcase
		end
	end

	// scoreboard
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (due_answers.size() == 0) begin
					$error("result with no outstanding transaction: status %0d name %h",
						status, found_name);
					fail_count++;
				end else begin
					mon_exp = due_answers.pop_front();
					if (status !== mon_exp.status) begin
						$error("status: expected %0d, actual %0d", mon_exp.status, status);
						fail_count++;
					end
					if (found_name !== mon_exp.name) begin
						$error("found_name: expected %h, actual %h", mon_exp.name, found_name);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				mon_new = table_step(op, key, entry_name);
				due_answers.push_back(mon_new);
				in_count <= in_count + 1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		bit [KEY_W-1:0] used_keys[$];
		bit [KEY_W-1:0] k;
		bit [KEY_W-1:0] last_k;
		bit [KEY_W-1:0] fill_key;
		int             r;
		int             need;
		logic           o;

		last_k = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, key zero, fast path, duplicates, empty names, wrap
		push_req(OP_LOOKUP, 16'd0, '1);
		push_req(OP_INSERT, 16'd0, 64'h1122_3344_0055_6677);
		push_req(OP_LOOKUP, 16'd0, '0);
		push_req(OP_LOOKUP, 16'd0, '0);
		push_req(OP_INSERT, 16'(HASH_SPAN), '1);
		push_req(OP_INSERT, 16'd0, 64'h0101_0101_0101_0101);
		push_req(OP_LOOKUP, 16'(HASH_SPAN), '0);
		push_req(OP_INSERT, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FF00);
		push_req(OP_LOOKUP, 16'hFFFF, '0);
		push_req(OP_INSERT, 16'hFFFF, 64'h0000_0000_0000_0001);
		push_req(OP_LOOKUP, 16'hFFFF, '0);
		push_req(OP_LOOKUP, 16'd0, '0);
		for (int n = 0; n < 6; n++)
			push_req(OP_INSERT, 16'(HASH_SPAN - 1 + n * HASH_SPAN), {$urandom, $urandom} | 64'h80);
		push_req(OP_LOOKUP, 16'(HASH_SPAN - 1 + 5 * HASH_SPAN), '0);
		push_req(OP_LOOKUP, 16'(HASH_SPAN - 1 + 6 * HASH_SPAN), '0);
		push_req(OP_INSERT, 16'hA5A5, 64'h5A5A_5A5A_5A5A_5A5A);
		push_req(OP_LOOKUP, 16'hA5A5, '1);
		wait_drained();

		for (int i = 0; i < RAND_ITEMS; i++) begin
			r = $urandom_range(0, 99);
			if (r < 40 && used_keys.size() > 0)
				k = used_keys[$urandom_range(0, used_keys.size() - 1)];
			else if (r < 60 && used_keys.size() > 0)
				k = 16'(int'(used_keys[$urandom_range(0, used_keys.size() - 1)]) % HASH_SPAN
					+ $urandom_range(0, 64) * HASH_SPAN);
			else if (r < 70)
				k = last_k;
			else
				k = 16'($urandom_range(0, 65535));
			o = ($urandom_range(0, 99) < 45) ? OP_INSERT : OP_LOOKUP;
			push_req(o, k, make_name());
			if (o == OP_INSERT)
				used_keys.push_back(k);
			last_k = k;
			if (i == RAND_ITEMS / 2)
				wait_drained();
		end
		wait_drained();

		// fill every slot so that probing goes full circle
		fill_key = 16'h8000;
		while (occupied < TABLE_SIZE) begin
			need = TABLE_SIZE - occupied;
			for (int j = 0; j < need; j++) begin
				push_req(OP_INSERT, fill_key, {$urandom, $urandom} | 64'h1);
				fill_key++;
			end
			wait_drained();
		end
		push_req(OP_LOOKUP, fill_key, '0);
		push_req(OP_INSERT, fill_key + 16'd1, '1);
		push_req(OP_LOOKUP, 16'h8000, '0);
		push_req(OP_LOOKUP, 16'h8000, '0);
		push_req(OP_INSERT, 16'h8001, '1);
		push_req(OP_LOOKUP, 16'd0, '0);
		push_req(OP_LOOKUP, 16'h7FFF, '0);
		wait_drained();

		repeat (40) @(negedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
